/* sv/cctrk_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and direction helpers for the chain code contour tracker.
// Used by cctrk_step and chain_code_contour_tracker; depends on nothing else.
package cctrk_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int COUNT_BITS_DEFAULT = 24;
    localparam int DIR_BITS           = 3;
    localparam int STATUS_BITS        = 2;
    localparam int TURN_BITS          = 4;

    localparam logic KIND_BEGIN  = 1'b0;
    localparam logic KIND_APPEND = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_NO_BEGIN = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [DIR_BITS-1:0] DIR_EAST       = 3'd0;
    localparam logic [DIR_BITS-1:0] DIR_NORTH_EAST = 3'd1;
    localparam logic [DIR_BITS-1:0] DIR_NORTH      = 3'd2;
    localparam logic [DIR_BITS-1:0] DIR_NORTH_WEST = 3'd3;
    localparam logic [DIR_BITS-1:0] DIR_WEST       = 3'd4;
    localparam logic [DIR_BITS-1:0] DIR_SOUTH_WEST = 3'd5;
    localparam logic [DIR_BITS-1:0] DIR_SOUTH      = 3'd6;
    localparam logic [DIR_BITS-1:0] DIR_SOUTH_EAST = 3'd7;

    typedef struct packed {
        logic                started;
        logic                have_codes;
        logic                hole_flag;
        logic [DIR_BITS-1:0] first_dir;
        logic [DIR_BITS-1:0] prev_dir;
    } track_flags_t;

    typedef logic signed [1:0] step_t;
    typedef logic signed [TURN_BITS-1:0] turn_t;

    function automatic step_t dir_dx(input logic [DIR_BITS-1:0] dir);
        step_t d;
        unique case (dir)
            DIR_EAST, DIR_NORTH_EAST, DIR_SOUTH_EAST: d = 2'sd1;
            DIR_NORTH, DIR_SOUTH:                     d = 2'sd0;
            default:                                  d = -2'sd1;
        endcase
        return d;
    endfunction

    function automatic step_t dir_dy(input logic [DIR_BITS-1:0] dir);
        step_t d;
        unique case (dir)
            DIR_NORTH_EAST, DIR_NORTH, DIR_NORTH_WEST: d = 2'sd1;
            DIR_EAST, DIR_WEST:                        d = 2'sd0;
            default:                                   d = -2'sd1;
        endcase
        return d;
    endfunction

    // The turn from one direction to the next, wrapped to the range -3 to 4.
    function automatic turn_t turn_step(input logic [DIR_BITS-1:0] now,
                                        input logic [DIR_BITS-1:0] prev);
        logic [DIR_BITS-1:0] diff;
        turn_t t;
        diff = now - prev;
        if (diff > 3'd4) begin
            t = $signed({1'b0, diff}) - 4'sd8;
        end else begin
            t = $signed({1'b0, diff});
        end
        return t;
    endfunction

endpackage

/* sv/chain_code_contour_tracker.sv */
`timescale 1ns / 1ps
// Top level of the chain code contour tracker: contour state and result register.
// Depends on cctrk_pkg and cctrk_step.
//
// Usage:
// The s_ channel carries one chain code transaction: s_kind selects a begin at
// (s_point_x, s_point_y) or an append of the Freeman direction s_code. The m_
// channel returns exactly one result per input transaction, showing the contour
// state after that step: end point, bounding box, turn sum, closed and hole
// flags, step counts and a status code.
// Each transaction is handled by the combinational next-state logic, and its
// result appears on the m_ channel in the cycle after acceptance. The block
// sustains one transaction per cycle while the receiver takes each result; the
// single result register sets the throughput.
// s_ready is high while the result register is empty or is being emptied in the
// same cycle, so a stalled receiver holds the result and blocks new input only
// until it takes it.
// Synchronous reset clears the contour state to zero, with no contour begun, and
// empties the result register.
module chain_code_contour_tracker #(
    parameter int COORD_BITS = cctrk_pkg::COORD_BITS_DEFAULT,
    parameter int COUNT_BITS = cctrk_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_kind,
    input  logic signed [COORD_BITS-1:0]          s_point_x,
    input  logic signed [COORD_BITS-1:0]          s_point_y,
    input  logic        [cctrk_pkg::DIR_BITS-1:0] s_code,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [COORD_BITS-1:0]          m_end_x,
    output logic signed [COORD_BITS-1:0]          m_end_y,
    output logic signed [COORD_BITS-1:0]          m_box_x_min,
    output logic signed [COORD_BITS-1:0]          m_box_x_max,
    output logic signed [COORD_BITS-1:0]          m_box_y_min,
    output logic signed [COORD_BITS-1:0]          m_box_y_max,
    output logic signed [COUNT_BITS-1:0]          m_turn_sum,
    output logic                                  m_closed,
    output logic                                  m_hole,
    output logic        [COUNT_BITS-1:0]          m_straight_steps,
    output logic        [COUNT_BITS-1:0]          m_diagonal_steps,
    output logic        [cctrk_pkg::STATUS_BITS-1:0] m_status
);
    import cctrk_pkg::*;

    track_flags_t                 flags_reg, flags_next;
    logic signed [COORD_BITS-1:0] origin_x_reg, origin_x_next;
    logic signed [COORD_BITS-1:0] origin_y_reg, origin_y_next;
    logic signed [COORD_BITS-1:0] tip_x_reg, tip_x_next;
    logic signed [COORD_BITS-1:0] tip_y_reg, tip_y_next;
    logic signed [COORD_BITS-1:0] x_min_reg, x_min_next;
    logic signed [COORD_BITS-1:0] x_max_reg, x_max_next;
    logic signed [COORD_BITS-1:0] y_min_reg, y_min_next;
    logic signed [COORD_BITS-1:0] y_max_reg, y_max_next;
    logic signed [COUNT_BITS-1:0] turn_total_reg, turn_total_next;
    logic        [COUNT_BITS-1:0] axis_count_reg, axis_count_next;
    logic        [COUNT_BITS-1:0] diag_count_reg, diag_count_next;
    logic                         step_closed;
    logic [STATUS_BITS-1:0]       step_status;

    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] out_end_x_reg, out_end_y_reg;
    logic signed [COORD_BITS-1:0] out_x_min_reg, out_x_max_reg;
    logic signed [COORD_BITS-1:0] out_y_min_reg, out_y_max_reg;
    logic signed [COUNT_BITS-1:0] out_turn_reg;
    logic                         out_closed_reg, out_hole_reg;
    logic        [COUNT_BITS-1:0] out_axis_reg, out_diag_reg;
    logic [STATUS_BITS-1:0]       out_status_reg;

    logic                         s_accept;

    assign s_ready  = !out_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    cctrk_step #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .flags           (flags_reg),
        .origin_x        (origin_x_reg),
        .origin_y        (origin_y_reg),
        .tip_x           (tip_x_reg),
        .tip_y           (tip_y_reg),
        .x_min           (x_min_reg),
        .x_max           (x_max_reg),
        .y_min           (y_min_reg),
        .y_max           (y_max_reg),
        .turn_total      (turn_total_reg),
        .axis_count      (axis_count_reg),
        .diag_count      (diag_count_reg),
        .kind            (s_kind),
        .point_x         (s_point_x),
        .point_y         (s_point_y),
        .code            (s_code),
        .flags_next      (flags_next),
        .origin_x_next   (origin_x_next),
        .origin_y_next   (origin_y_next),
        .tip_x_next      (tip_x_next),
        .tip_y_next      (tip_y_next),
        .x_min_next      (x_min_next),
        .x_max_next      (x_max_next),
        .y_min_next      (y_min_next),
        .y_max_next      (y_max_next),
        .turn_total_next (turn_total_next),
        .axis_count_next (axis_count_next),
        .diag_count_next (diag_count_next),
        .closed          (step_closed),
        .status          (step_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg      <= '0;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            tip_x_reg      <= '0;
            tip_y_reg      <= '0;
            x_min_reg      <= '0;
            x_max_reg      <= '0;
            y_min_reg      <= '0;
            y_max_reg      <= '0;
            turn_total_reg <= '0;
            axis_count_reg <= '0;
            diag_count_reg <= '0;
        end else if (s_accept) begin
            flags_reg      <= flags_next;
            origin_x_reg   <= origin_x_next;
            origin_y_reg   <= origin_y_next;
            tip_x_reg      <= tip_x_next;
            tip_y_reg      <= tip_y_next;
            x_min_reg      <= x_min_next;
            x_max_reg      <= x_max_next;
            y_min_reg      <= y_min_next;
            y_max_reg      <= y_max_next;
            turn_total_reg <= turn_total_next;
            axis_count_reg <= axis_count_next;
            diag_count_reg <= diag_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_end_x_reg  <= tip_x_next;
            out_end_y_reg  <= tip_y_next;
            out_x_min_reg  <= x_min_next;
            out_x_max_reg  <= x_max_next;
            out_y_min_reg  <= y_min_next;
            out_y_max_reg  <= y_max_next;
            out_turn_reg   <= turn_total_next;
            out_closed_reg <= step_closed;
            out_hole_reg   <= flags_next.hole_flag;
            out_axis_reg   <= axis_count_next;
            out_diag_reg   <= diag_count_next;
            out_status_reg <= step_status;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_end_x          = out_end_x_reg;
    assign m_end_y          = out_end_y_reg;
    assign m_box_x_min      = out_x_min_reg;
    assign m_box_x_max      = out_x_max_reg;
    assign m_box_y_min      = out_y_min_reg;
    assign m_box_y_max      = out_y_max_reg;
    assign m_turn_sum       = out_turn_reg;
    assign m_closed         = out_closed_reg;
    assign m_hole           = out_hole_reg;
    assign m_straight_steps = out_axis_reg;
    assign m_diagonal_steps = out_diag_reg;
    assign m_status         = out_status_reg;

    // An append before any begin must report the missing begin.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_kind == KIND_APPEND && !flags_reg.started)
        |=> (m_status == STATUS_NO_BEGIN))
    else $error("append before begin not reported");

    // A begin yields a closed contour with cleared sum and counts.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_kind == KIND_BEGIN)
        |=> (m_closed && m_turn_sum == '0 && m_straight_steps == '0 &&
             m_diagonal_steps == '0 && m_status == STATUS_OK))
    else $error("begin did not reset contour features");

    // A rejected step leaves the end point where it was.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && step_status == STATUS_OVERFLOW)
        |=> (m_end_x == $past(tip_x_reg) && m_end_y == $past(tip_y_reg)))
    else $error("end point moved on coordinate overflow");

    // The end point always lies inside the bounding box.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_box_x_min <= m_end_x && m_end_x <= m_box_x_max &&
                     m_box_y_min <= m_end_y && m_end_y <= m_box_y_max))
    else $error("end point outside bounding box");

endmodule

/* sv/cctrk_step.sv */
`timescale 1ns / 1ps
// Next-state logic of the contour tracker for one chain code transaction.
// Depends on cctrk_pkg for the flag struct, status codes and direction helpers.
module cctrk_step #(
    parameter int COORD_BITS = cctrk_pkg::COORD_BITS_DEFAULT,
    parameter int COUNT_BITS = cctrk_pkg::COUNT_BITS_DEFAULT
) (
    input  cctrk_pkg::track_flags_t              flags,
    input  logic signed [COORD_BITS-1:0]         origin_x,
    input  logic signed [COORD_BITS-1:0]         origin_y,
    input  logic signed [COORD_BITS-1:0]         tip_x,
    input  logic signed [COORD_BITS-1:0]         tip_y,
    input  logic signed [COORD_BITS-1:0]         x_min,
    input  logic signed [COORD_BITS-1:0]         x_max,
    input  logic signed [COORD_BITS-1:0]         y_min,
    input  logic signed [COORD_BITS-1:0]         y_max,
    input  logic signed [COUNT_BITS-1:0]         turn_total,
    input  logic        [COUNT_BITS-1:0]         axis_count,
    input  logic        [COUNT_BITS-1:0]         diag_count,
    input  logic                                 kind,
    input  logic signed [COORD_BITS-1:0]         point_x,
    input  logic signed [COORD_BITS-1:0]         point_y,
    input  logic        [cctrk_pkg::DIR_BITS-1:0] code,
    output cctrk_pkg::track_flags_t              flags_next,
    output logic signed [COORD_BITS-1:0]         origin_x_next,
    output logic signed [COORD_BITS-1:0]         origin_y_next,
    output logic signed [COORD_BITS-1:0]         tip_x_next,
    output logic signed [COORD_BITS-1:0]         tip_y_next,
    output logic signed [COORD_BITS-1:0]         x_min_next,
    output logic signed [COORD_BITS-1:0]         x_max_next,
    output logic signed [COORD_BITS-1:0]         y_min_next,
    output logic signed [COORD_BITS-1:0]         y_max_next,
    output logic signed [COUNT_BITS-1:0]         turn_total_next,
    output logic        [COUNT_BITS-1:0]         axis_count_next,
    output logic        [COUNT_BITS-1:0]         diag_count_next,
    output logic                                 closed,
    output logic        [cctrk_pkg::STATUS_BITS-1:0] status
);
    import cctrk_pkg::*;

    localparam logic signed [COUNT_BITS:0] TURN_MAX = {2'b00, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS:0] TURN_MIN = {2'b11, {(COUNT_BITS-1){1'b0}}};

    step_t                        dx;
    step_t                        dy;
    logic signed [COORD_BITS:0]   nx_wide;
    logic signed [COORD_BITS:0]   ny_wide;
    logic                         overflow;
    logic signed [COORD_BITS-1:0] nx;
    logic signed [COORD_BITS-1:0] ny;
    logic signed [COUNT_BITS-1:0] turn_mid;
    logic [DIR_BITS-1:0]          first_eff;
    logic                         at_origin;

    function automatic logic signed [COUNT_BITS-1:0] turn_add(
        input logic signed [COUNT_BITS-1:0] sum,
        input turn_t                        d
    );
        logic signed [COUNT_BITS:0] t;
        logic signed [COUNT_BITS-1:0] r;
        t = {sum[COUNT_BITS-1], sum} + {{(COUNT_BITS+1-TURN_BITS){d[TURN_BITS-1]}}, d};
        if (t > TURN_MAX) begin
            r = TURN_MAX[COUNT_BITS-1:0];
        end else if (t < TURN_MIN) begin
            r = TURN_MIN[COUNT_BITS-1:0];
        end else begin
            r = t[COUNT_BITS-1:0];
        end
        return r;
    endfunction

    assign dx       = dir_dx(code);
    assign dy       = dir_dy(code);
    assign nx_wide  = {tip_x[COORD_BITS-1], tip_x} + {{(COORD_BITS-1){dx[1]}}, dx};
    assign ny_wide  = {tip_y[COORD_BITS-1], tip_y} + {{(COORD_BITS-1){dy[1]}}, dy};
    assign overflow = (nx_wide[COORD_BITS] != nx_wide[COORD_BITS-1]) ||
                      (ny_wide[COORD_BITS] != ny_wide[COORD_BITS-1]);
    assign nx        = nx_wide[COORD_BITS-1:0];
    assign ny        = ny_wide[COORD_BITS-1:0];
    assign at_origin = (nx == origin_x) && (ny == origin_y);
    assign first_eff = flags.have_codes ? flags.first_dir : code;
    assign turn_mid  = flags.have_codes ? turn_add(turn_total, turn_step(code, flags.prev_dir))
                                        : '0;

    always_comb begin
        flags_next      = flags;
        origin_x_next   = origin_x;
        origin_y_next   = origin_y;
        tip_x_next      = tip_x;
        tip_y_next      = tip_y;
        x_min_next      = x_min;
        x_max_next      = x_max;
        y_min_next      = y_min;
        y_max_next      = y_max;
        turn_total_next = turn_total;
        axis_count_next = axis_count;
        diag_count_next = diag_count;
        status          = STATUS_OK;
        if (kind == KIND_BEGIN) begin
            flags_next      = '0;
            flags_next.started = 1'b1;
            origin_x_next   = point_x;
            origin_y_next   = point_y;
            tip_x_next      = point_x;
            tip_y_next      = point_y;
            x_min_next      = point_x;
            x_max_next      = point_x;
            y_min_next      = point_y;
            y_max_next      = point_y;
            turn_total_next = '0;
            axis_count_next = '0;
            diag_count_next = '0;
        end else if (!flags.started) begin
            status = STATUS_NO_BEGIN;
        end else if (overflow) begin
            status = STATUS_OVERFLOW;
        end else begin
            tip_x_next = nx;
            tip_y_next = ny;
            if (nx < x_min) begin
                x_min_next = nx;
            end
            if (nx > x_max) begin
                x_max_next = nx;
            end
            if (ny < y_min) begin
                y_min_next = ny;
            end
            if (ny > y_max) begin
                y_max_next = ny;
            end
            flags_next.have_codes = 1'b1;
            flags_next.first_dir  = first_eff;
            flags_next.prev_dir   = code;
            if (code[0]) begin
                diag_count_next = (&diag_count) ? diag_count : diag_count + 1'b1;
            end else begin
                axis_count_next = (&axis_count) ? axis_count : axis_count + 1'b1;
            end
            turn_total_next = turn_mid;
            if (at_origin) begin
                turn_total_next      = turn_add(turn_mid, turn_step(first_eff, code));
                flags_next.hole_flag = turn_total_next[COUNT_BITS-1];
            end
        end
    end

    assign closed = flags_next.started && (tip_x_next == origin_x_next) &&
                    (tip_y_next == origin_y_next);

endmodule
